// File: rtl/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg
// shared types and constants of the minimum spanning tree block
// ----------------------------------------------------------------------------
`default_nettype none

package pmst_pkg;

   localparam int WEIGHT_W   = 32;
   localparam int EDGE_NUM_W = 11;
   localparam int NODE_OUT_W = 6;
   localparam int STEP_OUT_W = 6;
   localparam int CFG_W      = 7;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;

   // sequencer states
   localparam logic [1:0] ST_LOAD   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_OUT    = 2'd3;

   typedef struct packed {
      logic                  present;
      logic [WEIGHT_W-1:0]   weight;
      logic [EDGE_NUM_W-1:0] number;
   } edge_entry_type;

endpackage

`default_nettype wire

// File: rtl/prim_minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree
// dense prim spanning tree over a streamed distance matrix
//
// req channel: one matrix entry per beat, row-major, node_count squared beats
// per matrix; entries above the diagonal with dist_present set become edges,
// numbered in arrival order. loading takes one beat per cycle.
// after the last entry the tree phase starts from node 0 and req_tready drops
// until the final result has been taken.
// each tree step is one pass over the row of the newly joined node through the
// one-read-per-cycle edge memory and the per-node key memory (read, update,
// write back). the first pass seeds the keys from node 0. one result per
// joined node, rsp_tlast on the last one.
// a disconnected graph gives one result with rsp_tuser set and rsp_tlast set.
// a stalled rsp channel holds the result register and freezes the sequencer.
// reset clears control state and sets node_count to 64 (MAX_NODES if smaller);
// the memories need no clearing since every entry read was written during the
// current load. a csr write clamps node_count to 2..MAX_NODES and restarts the load.
// ----------------------------------------------------------------------------
`default_nettype none

module prim_minimum_spanning_tree #(
   parameter int MAX_NODES = 64
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wen,
   input  wire  [pmst_pkg::CFG_W-1:0]          csr_wdata,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [31:0] dist_weight
   input  wire  [pmst_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] dist_present
   input  wire                                 req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [5:0] parent_node, [11:6] child_node, [22:12] edge_number,
   // [54:23] edge_weight, [60:55] step_index, [63:61] zero
   output logic [pmst_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] disconnected
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import pmst_pkg::*;

   localparam int NW          = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int NCW         = $clog2(MAX_NODES + 1);
   localparam int ADDR_W      = 2 * NW;
   localparam int EDGE_DEPTH  = 1 << ADDR_W;
   localparam int RESET_NODES = (MAX_NODES < 64) ? MAX_NODES : 64;
   localparam int PAD_W       = RSP_DATA_W - 2 * NODE_OUT_W - EDGE_NUM_W - WEIGHT_W
                                - STEP_OUT_W;

   typedef struct packed {
      logic                  in_tree;
      logic                  valid;
      logic [WEIGHT_W-1:0]   weight;
      logic [NW-1:0]         parent;
      logic [EDGE_NUM_W-1:0] number;
   } key_entry_type;

   // memories
   edge_entry_type edge_mem [EDGE_DEPTH];
   key_entry_type  key_mem  [MAX_NODES];

   logic [1:0]            state_ff;
   logic [NCW-1:0]        node_count_ff;
   logic [NCW-1:0]        node_count_in;
   logic [NCW-1:0]        last_node;
   logic [NW-1:0]         row_ff;
   logic [NW-1:0]         col_ff;
   logic [EDGE_NUM_W-1:0] edge_cnt_ff;
   logic [NW-1:0]         step_ff;
   logic [NW-1:0]         cur_c_ff;
   logic                  first_pass_ff;

   // scan pipeline
   logic                  issuing_ff;
   logic [NW-1:0]         issue_k_ff;
   logic                  a_valid_ff;
   logic [NW-1:0]         a_k_ff;
   edge_entry_type        edge_rd_ff;
   key_entry_type         key_rd_ff;
   logic                  b_valid_ff;
   logic [NW-1:0]         b_k_ff;
   key_entry_type         b_key_ff;

   logic                  best_found_ff;
   logic [WEIGHT_W-1:0]   best_w_ff;
   logic [NW-1:0]         best_p_ff;
   logic [NW-1:0]         best_k_ff;
   logic [EDGE_NUM_W-1:0] best_e_ff;

   logic                  rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                  rsp_tuser_ff;
   logic                  rsp_tlast_ff;

   logic                  req_beat;
   logic                  edge_we;
   logic [ADDR_W-1:0]     edge_waddr;
   logic [ADDR_W-1:0]     edge_raddr;
   logic                  row_end;
   logic                  col_end;
   logic                  issue_end;
   logic                  scan_done;
   key_entry_type         key_old;
   key_entry_type         key_in;
   logic                  key_better;
   logic                  cand_better;

   assign last_node  = node_count_ff - NCW'(1);
   assign req_tready = (state_ff == ST_LOAD);
   assign req_beat   = req_tvalid && req_tready;
   assign col_end    = (NCW'(col_ff) == last_node);
   assign row_end    = (NCW'(row_ff) == last_node);
   assign issue_end  = (NCW'(issue_k_ff) == last_node);
   assign scan_done  = (state_ff == ST_SCAN) && !issuing_ff && !a_valid_ff && !b_valid_ff;

   // clamp of the written node count
   always_comb begin
      priority if (csr_wdata < CFG_W'(2)) begin
         node_count_in = NCW'(2);
      end else if (32'(csr_wdata) > 32'(MAX_NODES)) begin
         node_count_in = NCW'(MAX_NODES);
      end else begin
         node_count_in = NCW'(csr_wdata);
      end
   end

   // edge memory: load writes, scan reads the row of the joined node
   assign edge_we    = req_beat && (col_ff > row_ff);
   assign edge_waddr = {row_ff, col_ff};
   assign edge_raddr = (issue_k_ff < cur_c_ff) ? {issue_k_ff, cur_c_ff}
                                               : {cur_c_ff, issue_k_ff};

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= '{present: req_tuser,
                                   weight:  req_tdata[WEIGHT_W-1:0],
                                   number:  edge_cnt_ff};
      end
      edge_rd_ff <= edge_mem[edge_raddr];
   end

   // key update of node a_k against the newly joined node
   always_comb begin
      key_old    = first_pass_ff ? key_entry_type'('0) : key_rd_ff;
      key_in     = key_old;
      key_better = edge_rd_ff.present &&
                   (!key_old.valid || (edge_rd_ff.weight < key_old.weight) ||
                    ((edge_rd_ff.weight == key_old.weight) && (cur_c_ff < key_old.parent)));
      key_in.in_tree = key_old.in_tree || (a_k_ff == cur_c_ff);
      if (!key_in.in_tree && key_better) begin
         key_in.valid  = 1'b1;
         key_in.weight = edge_rd_ff.weight;
         key_in.parent = cur_c_ff;
         key_in.number = edge_rd_ff.number;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         key_mem[a_k_ff] <= key_in;
      end
      key_rd_ff <= key_mem[issue_k_ff];
   end

   assign cand_better = b_key_ff.valid && !b_key_ff.in_tree &&
                        (!best_found_ff || (b_key_ff.weight < best_w_ff) ||
                         ((b_key_ff.weight == best_w_ff) && (b_key_ff.parent < best_p_ff)));

   // payload registers
   always_ff @(posedge clock) begin
      b_k_ff   <= a_k_ff;
      b_key_ff <= key_in;
      if (b_valid_ff && cand_better) begin
         best_w_ff <= b_key_ff.weight;
         best_p_ff <= b_key_ff.parent;
         best_k_ff <= b_k_ff;
         best_e_ff <= b_key_ff.number;
      end
      if (state_ff == ST_DECIDE) begin
         rsp_tuser_ff <= !best_found_ff;
         rsp_tlast_ff <= !best_found_ff || (NCW'(step_ff) == last_node);
         if (best_found_ff) begin
            rsp_tdata_ff <= {PAD_W'(0), STEP_OUT_W'(step_ff), best_w_ff, best_e_ff,
                             NODE_OUT_W'(best_k_ff), NODE_OUT_W'(best_p_ff)};
         end else begin
            rsp_tdata_ff <= {PAD_W'(0), STEP_OUT_W'(step_ff), WEIGHT_W'(0),
                             EDGE_NUM_W'(0), NODE_OUT_W'(0), NODE_OUT_W'(0)};
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         node_count_ff <= NCW'(RESET_NODES);
         row_ff        <= '0;
         col_ff        <= '0;
         edge_cnt_ff   <= '0;
         step_ff       <= '0;
         cur_c_ff      <= '0;
         first_pass_ff <= 1'b0;
         issuing_ff    <= 1'b0;
         issue_k_ff    <= '0;
         a_valid_ff    <= 1'b0;
         a_k_ff        <= '0;
         b_valid_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         a_valid_ff <= issuing_ff;
         a_k_ff     <= issue_k_ff;
         b_valid_ff <= a_valid_ff;
         if (issuing_ff) begin
            if (issue_end) begin
               issuing_ff <= 1'b0;
            end else begin
               issue_k_ff <= issue_k_ff + NW'(1);
            end
         end
         if (b_valid_ff && cand_better) begin
            best_found_ff <= 1'b1;
         end
         if (csr_wen) begin
            node_count_ff <= node_count_in;
            row_ff        <= '0;
            col_ff        <= '0;
            edge_cnt_ff   <= '0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_beat && !csr_wen) begin
                  if (edge_we && req_tuser) begin
                     edge_cnt_ff <= edge_cnt_ff + EDGE_NUM_W'(1);
                  end
                  if (col_end) begin
                     col_ff <= '0;
                     if (row_end) begin
                        row_ff        <= '0;
                        edge_cnt_ff   <= '0;
                        state_ff      <= ST_SCAN;
                        step_ff       <= NW'(1);
                        cur_c_ff      <= '0;
                        first_pass_ff <= 1'b1;
                        issuing_ff    <= 1'b1;
                        issue_k_ff    <= '0;
                        best_found_ff <= 1'b0;
                     end else begin
                        row_ff <= row_ff + NW'(1);
                     end
                  end else begin
                     col_ff <= col_ff + NW'(1);
                  end
               end
            end
            ST_SCAN: begin
               if (scan_done) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               rsp_tvalid_ff <= 1'b1;
               state_ff      <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  rsp_tvalid_ff <= 1'b0;
                  if (rsp_tlast_ff) begin
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff      <= ST_SCAN;
                     step_ff       <= step_ff + NW'(1);
                     cur_c_ff      <= best_k_ff;
                     first_pass_ff <= 1'b0;
                     issuing_ff    <= 1'b1;
                     issue_k_ff    <= '0;
                     best_found_ff <= 1'b0;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

`default_nettype wire

// File: sim/prim_minimum_spanning_tree_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_tb
// self-checking bench for the streamed dense spanning tree block
//
// distance matrices are streamed over req with random gaps while rsp stalls
// at random. the bench keeps its own edge store, grows the tree from node 0
// with the same tie rules and checks every rsp beat field by field against
// the oldest predicted edge. a short table of directed beats comes first,
// then random matrices of many sizes, densities and weight mixes, then a
// partial load at the clamped 64-node size.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_tb;
   import pmst_pkg::*;

   localparam int TB_NODES    = 64;
   localparam int ITEM_GOAL   = 410;
   localparam int FINAL_BEATS = 40;
   localparam int IDLE_LIMIT  = 3000;
   localparam int DRAIN_WAIT  = 8;
   localparam int END_WAIT    = 150;
   localparam int LONG_HOLD   = 300;
   localparam int DIR_LEN     = 29;

   typedef struct packed {
      logic [5:0]  parent;
      logic [5:0]  child;
      logic [10:0] number;
      logic [31:0] weight;
      logic [5:0]  step;
      logic        disc;
      logic        last;
   } span_edge_type;

   typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [31:0]   value;
      logic          present;
      logic          typed;
      span_edge_type result;
   } stim_row_type;

   localparam span_edge_type NO_EDGE = '0;

   localparam stim_row_type DIR_ROWS [DIR_LEN] = '{
      // node_count 0 clamps to 2; heaviest weight
      '{ROW_CFG,  32'd0,        1'b0, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'hffffffff, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'hffffffff, 1'b0, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b0, 1'b1,
        '{6'd0, 6'd1, 11'd0, 32'hffffffff, 6'd1, 1'b0, 1'b1}},
      // only edge absent: disconnected at step 1
      '{ROW_BEAT, 32'hffffffff, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h12345678, 1'b0, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'hffffffff, 1'b1, 1'b1,
        '{6'd0, 6'd0, 11'd0, 32'h0, 6'd1, 1'b1, 1'b1}},
      // node_count 1 clamps to 2; zero weight
      '{ROW_CFG,  32'd1,        1'b0, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b0, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b1,
        '{6'd0, 6'd1, 11'd0, 32'h0, 6'd1, 1'b0, 1'b1}},
      // partial load, then a csr write restarts it
      '{ROW_CFG,  32'd3,        1'b0, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000001, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000009, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000009, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000009, 1'b1, 1'b0, NO_EDGE},
      '{ROW_CFG,  32'd3,        1'b0, 1'b0, NO_EDGE},
      // equal weights everywhere, lighter entries below the diagonal
      '{ROW_BEAT, 32'h00000005, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000005, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000005, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000005, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000005, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b0, NO_EDGE},
      '{ROW_BEAT, 32'h00000000, 1'b1, 1'b0, NO_EDGE}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wen = 1'b0;
   logic [CFG_W-1:0]       csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // predicted edge store and load state
   logic                   dist_known [TB_NODES][TB_NODES];
   logic [31:0]            dist_wt    [TB_NODES][TB_NODES];
   logic [10:0]            dist_rank  [TB_NODES][TB_NODES];
   int unsigned            nodes_in_use = TB_NODES;
   int unsigned            load_pos = 0;
   int unsigned            edge_count = 0;
   span_edge_type          pending_edges [$];

   int                     mismatches = 0;
   int                     idle_cycles = 0;
   int unsigned            beats_sent = 0;
   bit                     sender_burst = 1'b0;
   logic                   row_typed = 1'b0;
   span_edge_type          row_result = '0;

   prim_minimum_spanning_tree #(
      .MAX_NODES (TB_NODES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void append_edge(span_edge_type e);
      pending_edges.insert(pending_edges.size(), e);
   endfunction

   function automatic void set_node_count(logic [CFG_W-1:0] v);
      if (v < 2)
         nodes_in_use = 2;
      else if (v > TB_NODES)
         nodes_in_use = TB_NODES;
      else
         nodes_in_use = 32'(v);
      load_pos = 0;
      edge_count = 0;
   endfunction

   // prim from node 0: lightest crossing edge, ties to lowest tree node then child
   function automatic void grow_tree();
      bit            joined [TB_NODES];
      bit            found;
      int unsigned   best_p, best_c, lo, hi;
      logic [31:0]   best_w;
      logic [10:0]   best_n;
      span_edge_type e;
      joined = '{default: 1'b0};
      joined[0] = 1'b1;
      for (int unsigned step = 1; step < nodes_in_use; step++) begin
         found = 1'b0;
         best_p = 0;
         best_c = 0;
         best_w = '0;
         best_n = '0;
         for (int unsigned j = 0; j < nodes_in_use; j++) begin
            if (joined[j]) begin
               for (int unsigned k = 0; k < nodes_in_use; k++) begin
                  if (k != j && !joined[k]) begin
                     lo = (j < k) ? j : k;
                     hi = (j < k) ? k : j;
                     if (dist_known[lo][hi] && (!found || dist_wt[lo][hi] < best_w)) begin
                        found = 1'b1;
                        best_p = j;
                        best_c = k;
                        best_w = dist_wt[lo][hi];
                        best_n = dist_rank[lo][hi];
                     end
                  end
               end
            end
         end
         e = NO_EDGE;
         e.step = 6'(step);
         if (!found) begin
            e.disc = 1'b1;
            e.last = 1'b1;
            append_edge(e);
            return;
         end
         joined[best_c] = 1'b1;
         e.parent = 6'(best_p);
         e.child = 6'(best_c);
         e.number = best_n;
         e.weight = best_w;
         e.last = (step == nodes_in_use - 1);
         append_edge(e);
      end
   endfunction

   function automatic void absorb_entry(logic [31:0] w, logic p, logic typed,
                                        span_edge_type res);
      int unsigned row, col;
      row = load_pos / nodes_in_use;
      col = load_pos % nodes_in_use;
      if (col > row) begin
         dist_known[row][col] = p;
         dist_wt[row][col] = w;
         dist_rank[row][col] = edge_count[10:0];
         if (p)
            edge_count = (edge_count + 1) & 32'h7ff;
      end
      load_pos++;
      if (load_pos == nodes_in_use * nodes_in_use) begin
         load_pos = 0;
         edge_count = 0;
         if (typed)
            append_edge(res);
         else
            grow_tree();
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_edge();
      span_edge_type e;
      if (pending_edges.size() == 0) begin
         $display("%0t: rsp beat with no edge expected, tdata %0h", $time, rsp_tdata);
         mismatches++;
         return;
      end
      e = pending_edges.pop_front();
      check_field("parent_node", 32'(e.parent), 32'(rsp_tdata[5:0]));
      check_field("child_node", 32'(e.child), 32'(rsp_tdata[11:6]));
      check_field("edge_number", 32'(e.number), 32'(rsp_tdata[22:12]));
      check_field("edge_weight", e.weight, rsp_tdata[54:23]);
      check_field("step_index", 32'(e.step), 32'(rsp_tdata[60:55]));
      check_field("tdata pad", '0, 32'(rsp_tdata[63:61]));
      check_field("disconnected", 32'(e.disc), 32'(rsp_tuser));
      check_field("last", 32'(e.last), 32'(rsp_tlast));
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wen)
            set_node_count(csr_wdata);
         if (req_tvalid && req_tready)
            absorb_entry(req_tdata, req_tuser, row_typed, row_result);
         if (rsp_tvalid && rsp_tready)
            check_edge();
         if (csr_wen || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic logic [31:0] pick_weight(int unsigned mode);
      case (mode)
         0: return $urandom_range(0, 3);
         1: return $urandom();
         default: return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
      endcase
   endfunction

   task automatic send_beat(logic [31:0] w, logic p, logic typed, span_edge_type res);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      req_tuser <= p;
      row_typed <= typed;
      row_result <= res;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_edges.size() != 0) @(negedge clock);
   endtask

   task automatic write_node_count(logic [CFG_W-1:0] v);
      wait_for_drain();
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic send_matrix(int unsigned n);
      int unsigned density, wmode;
      case ($urandom_range(0, 4))
         0, 1: density = 100;
         2: density = 90;
         3: density = 50;
         default: density = 15;
      endcase
      wmode = $urandom_range(0, 2);
      sender_burst = ($urandom_range(0, 2) == 0);
      repeat (n * n)
         send_beat(pick_weight(wmode), ($urandom_range(0, 99) < density), 1'b0, NO_EDGE);
   endtask

   // rsp side: random stalls, bursts without stalls, one long hold-off
   initial begin
      int gap;
      int taken;
      bit burst;
      bit held;
      taken = 0;
      burst = 1'b0;
      held = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (taken % 16 == 0)
            burst = ($urandom_range(0, 2) == 0);
         gap = burst ? 0 : $urandom_range(0, 4);
         if (!held && taken >= 30 && req_tvalid && !req_tready) begin
            gap = LONG_HOLD;
            held = 1'b1;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   initial begin
      int unsigned cfg_val;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_LEN; i++) begin
         if (DIR_ROWS[i].kind == ROW_CFG)
            write_node_count(DIR_ROWS[i].value[CFG_W-1:0]);
         else
            send_beat(DIR_ROWS[i].value, DIR_ROWS[i].present, DIR_ROWS[i].typed,
                      DIR_ROWS[i].result);
      end

      while (beats_sent < ITEM_GOAL) begin
         // occasionally abandon a partial matrix with the next csr write
         if ($urandom_range(0, 5) == 0) begin
            sender_burst = 1'b0;
            repeat ($urandom_range(1, nodes_in_use * nodes_in_use - 1))
               send_beat(pick_weight(1), 1'($urandom_range(0, 1)), 1'b0, NO_EDGE);
         end
         if ($urandom_range(0, 9) == 0)
            cfg_val = $urandom_range(0, 1);
         else if ($urandom_range(0, 5) == 0)
            cfg_val = $urandom_range(7, 12);
         else
            cfg_val = $urandom_range(2, 6);
         write_node_count(cfg_val[CFG_W-1:0]);
         repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 5) == 0)
               wait_for_drain();
            send_matrix(nodes_in_use);
         end
      end

      // largest setting, written above range so it clamps to 64; no result yet
      write_node_count('1);
      sender_burst = 1'b0;
      repeat (FINAL_BEATS)
         send_beat(pick_weight(1), 1'($urandom_range(0, 1)), 1'b0, NO_EDGE);

      wait_for_drain();
      repeat (END_WAIT) @(negedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
